@@ rtl/qpps_pkg.sv @@
// Shared types and constants for the polyline path sampler.
`timescale 1ns / 1ps
package qpps_pkg;

  localparam int POS_W   = 24;
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 32;
  localparam int MIN_W   = 16;
  localparam int D2_W    = 50;  // squared distance, three squares of 25-bit differences of 24-bit positions
  localparam int QUO_W   = 25;  // quotient bits produced by the divider
  localparam int DVD_W   = 57;  // divider dividend width
  localparam int STEP_W  = 5;
  localparam logic [STEP_W-1:0] SQRT_LAST = 5'd24;
  localparam logic [STEP_W-1:0] DIV_LAST  = 5'd24;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic CFG_DURATION = 1'b0;
  localparam logic CFG_MIN_SEG  = 1'b1;

  localparam logic [TIME_W-1:0] DURATION_RST = 32'd24000000;
  localparam logic [MIN_W-1:0]  MIN_SEG_RST  = 16'd1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef logic [4:0] dp_op_t;

  localparam dp_op_t DP_NOP       = 5'd0;
  localparam dp_op_t DP_LATCH     = 5'd1;
  localparam dp_op_t DP_FIRST     = 5'd2;
  localparam dp_op_t DP_RD_LAST   = 5'd3;
  localparam dp_op_t DP_RD_FIRST  = 5'd4;
  localparam dp_op_t DP_SQ_X      = 5'd5;
  localparam dp_op_t DP_SQ_Y      = 5'd6;
  localparam dp_op_t DP_SQ_Z      = 5'd7;
  localparam dp_op_t DP_SQRT_INIT = 5'd8;
  localparam dp_op_t DP_SQRT_STEP = 5'd9;
  localparam dp_op_t DP_APPEND    = 5'd10;
  localparam dp_op_t DP_CMD_RD    = 5'd11;
  localparam dp_op_t DP_DIV_T     = 5'd12;
  localparam dp_op_t DP_DIV_STEP  = 5'd13;
  localparam dp_op_t DP_POW_INIT  = 5'd14;
  localparam dp_op_t DP_POW       = 5'd15;
  localparam dp_op_t DP_ACC10     = 5'd16;
  localparam dp_op_t DP_ACC15     = 5'd17;
  localparam dp_op_t DP_ACC6      = 5'd18;
  localparam dp_op_t DP_TARGET    = 5'd19;
  localparam dp_op_t DP_SRCH_INIT = 5'd20;
  localparam dp_op_t DP_SRCH_RD   = 5'd21;
  localparam dp_op_t DP_SRCH_CMP  = 5'd22;
  localparam dp_op_t DP_RD_K      = 5'd23;
  localparam dp_op_t DP_CAP_K     = 5'd24;
  localparam dp_op_t DP_CAP_J     = 5'd25;
  localparam dp_op_t DP_SEG       = 5'd26;
  localparam dp_op_t DP_CMD_J     = 5'd27;
  localparam dp_op_t DP_LERP_MUL  = 5'd28;
  localparam dp_op_t DP_LERP_OUT  = 5'd29;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       full;
    logic       fin;
    logic       ready;
    logic       d2_gt;
    logic       srch_more;
    logic       seg_zero;
  } dp_stat_t;

endpackage

@@ rtl/quintic_polyline_path_sampler_unit.sv @@
// Top level of the quintic-timed polyline path sampler.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in_     | input     | in_valid / in_ready    | operation, pos_x/y/z, elapsed_us
//   out_    | output    | out_valid / out_ready  | cmd_x/y/z, status flags, count, length
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index (0 duration, 1 min segment)
//
// One word is worked on at a time; the controller walks the datapath through it.
// Start writes the first point; append measures the new span with the 25-step square root;
// a sample on a ready path runs a 25-step time divide, a binary search over the stored
// lengths, and three 25-step lerp divides on one divider.
// A finished word waits in the output register while the next word is accepted.
// Reset (rst_n low, synchronous) empties the path and restores both registers;
// the point store itself is not cleared. cfg_ready is always high.
`timescale 1ns / 1ps
module quintic_polyline_path_sampler_unit #(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [31:0]        in_elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_cmd_x,
  output logic signed [23:0] out_cmd_y,
  output logic signed [23:0] out_cmd_z,
  output logic               out_path_ready,
  output logic               out_finished,
  output logic               out_point_accepted,
  output logic [8:0]         out_point_count,
  output logic [31:0]        out_path_length_um,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import qpps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration is taken every cycle
  assign cfg_ready = 1'b1;

  qpps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qpps_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_elapsed_us      (in_elapsed_us),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_cmd_x          (out_cmd_x),
    .out_cmd_y          (out_cmd_y),
    .out_cmd_z          (out_cmd_z),
    .out_path_ready     (out_path_ready),
    .out_finished       (out_finished),
    .out_point_accepted (out_point_accepted),
    .out_point_count    (out_point_count),
    .out_path_length_um (out_path_length_um)
  );

endmodule

@@ rtl/qpps_dp.sv @@
// Datapath: point store, distance and square root, divider, quintic smoothstep, search, lerp.
`timescale 1ns / 1ps
module qpps_dp #(
  parameter int MAX_POINTS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  qpps_pkg::dp_cmd_t               cmd,
  output qpps_pkg::dp_stat_t              stat,
  input  logic [1:0]                      in_operation,
  input  logic signed [23:0]              in_pos_x,
  input  logic signed [23:0]              in_pos_y,
  input  logic signed [23:0]              in_pos_z,
  input  logic [31:0]                     in_elapsed_us,
  input  logic                            cfg_valid,
  input  logic                            cfg_index,
  input  logic [31:0]                     cfg_data,
  output logic signed [23:0]              out_cmd_x,
  output logic signed [23:0]              out_cmd_y,
  output logic signed [23:0]              out_cmd_z,
  output logic                            out_path_ready,
  output logic                            out_finished,
  output logic                            out_point_accepted,
  output logic [8:0]                      out_point_count,
  output logic [31:0]                     out_path_length_um
);
  import qpps_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [TIME_W-1:0] dur_r;
  logic [MIN_W-1:0]  min_r;
  logic [CW-1:0]     cnt_r;
  logic [LEN_W-1:0]  tot_r;

  logic [1:0]              op_r;
  logic signed [POS_W-1:0] pin_r [3];
  logic [TIME_W-1:0]       el_r;
  logic                    fin_r;
  logic                    acc_r;
  logic signed [POS_W-1:0] w_r [3];

  logic signed [POS_W-1:0] mem_x [MAX_POINTS];
  logic signed [POS_W-1:0] mem_y [MAX_POINTS];
  logic signed [POS_W-1:0] mem_z [MAX_POINTS];
  logic [LEN_W-1:0]        mem_c [MAX_POINTS];
  logic signed [POS_W-1:0] rd_r [3];
  logic [LEN_W-1:0]        rd_c_r;
  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_wa, mem_ra;
  logic [LEN_W-1:0]        mem_wc;

  logic [D2_W-1:0] d2_r;
  logic [31:0]     m2_r;
  logic [D2_W-1:0] sq_v_r, sq_r_r, sq_b_r;
  logic [31:0]     rem_r, dv_r;
  logic [QUO_W-1:0] dq_r;
  logic [16:0]     t_r, pw_r;
  logic signed [22:0] p_r;
  logic [LEN_W-1:0] tgt_r;
  logic [AW-1:0]   lo_r, hi_r, mid_r;
  logic signed [POS_W-1:0] pa_r [3];
  logic signed [POS_W-1:0] pb_r [3];
  logic [LEN_W-1:0] c0_r, c1_r, seg_r, num_r;
  logic            seg_zero_r, neg_r;

  // combinational helpers
  logic [CW-1:0]     cnt_m1;
  logic [AW:0]       mid_sum;
  logic [AW-1:0]     mid;
  logic signed [24:0] dsel;
  logic [49:0]       dsq;
  logic [D2_W-1:0]   sq_t;
  logic [32:0]       len_sum;
  logic [LEN_W-1:0]  len_sat;
  logic [32:0]       trial;
  logic              tge;
  logic [33:0]       pw_prod;
  logic [34:0]       pw_rnd;
  logic [16:0]       pclamp;
  logic [48:0]       tprod;
  logic signed [24:0] ldiff;
  logic [24:0]       lmag;
  logic [DVD_W-1:0]  ldvd;
  logic signed [24:0] lres;
  logic [DVD_W-1:0]  tdvd;
  logic [CW+8:0]     cnt_ext;

  assign cnt_m1  = cnt_r - CW'(1);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];

  always_comb begin
    case (cmd.op)
      DP_SQ_Y: dsel = {pin_r[1][23], pin_r[1]} - {rd_r[1][23], rd_r[1]};
      DP_SQ_Z: dsel = {pin_r[2][23], pin_r[2]} - {rd_r[2][23], rd_r[2]};
      default: dsel = {pin_r[0][23], pin_r[0]} - {rd_r[0][23], rd_r[0]};
    endcase
  end
  assign dsq = $unsigned(50'(dsel) * 50'(dsel));

  assign sq_t    = sq_r_r + sq_b_r;
  assign len_sum = {1'b0, tot_r} + 33'(sq_r_r[24:0]);
  assign len_sat = len_sum[32] ? {LEN_W{1'b1}} : len_sum[31:0];

  assign trial = {rem_r, dq_r[QUO_W-1]};
  assign tge   = trial >= {1'b0, dv_r};

  assign pw_prod = pw_r * t_r;
  assign pw_rnd  = {1'b0, pw_prod} + 35'd32768;

  always_comb begin
    if (p_r < 0) pclamp = 17'd0;
    else if (p_r > 23'sd65536) pclamp = 17'd65536;
    else pclamp = p_r[16:0];
  end
  assign tprod = pclamp * tot_r;

  assign ldiff = {pb_r[cmd.axis][23], pb_r[cmd.axis]} - {pa_r[cmd.axis][23], pa_r[cmd.axis]};
  assign lmag  = ldiff[24] ? 25'(-ldiff) : 25'(ldiff);
  assign ldvd  = DVD_W'(lmag) * DVD_W'(num_r) + DVD_W'(seg_r >> 1);
  assign lres  = neg_r ? ({pa_r[cmd.axis][23], pa_r[cmd.axis]} - $signed(dq_r))
                       : ({pa_r[cmd.axis][23], pa_r[cmd.axis]} + $signed(dq_r));
  assign tdvd  = {9'd0, el_r, 16'd0};

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wc = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    case (cmd.op)
      DP_FIRST: begin
        mem_we = 1'b1;
      end
      DP_APPEND: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[AW-1:0];
        mem_wc = len_sat;
      end
      DP_RD_LAST: begin
        mem_re = 1'b1;
        mem_ra = cnt_m1[AW-1:0];
      end
      DP_RD_FIRST: begin
        mem_re = 1'b1;
      end
      DP_SRCH_RD: begin
        mem_re = 1'b1;
        mem_ra = mid;
      end
      DP_RD_K: begin
        mem_re = 1'b1;
        mem_ra = lo_r;
      end
      DP_CAP_K: begin
        mem_re = 1'b1;
        mem_ra = lo_r - AW'(1);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[mem_wa] <= pin_r[0];
      mem_y[mem_wa] <= pin_r[1];
      mem_z[mem_wa] <= pin_r[2];
      mem_c[mem_wa] <= mem_wc;
    end
    if (mem_re) begin
      rd_r[0] <= mem_x[mem_ra];
      rd_r[1] <= mem_y[mem_ra];
      rd_r[2] <= mem_z[mem_ra];
      rd_c_r  <= mem_c[mem_ra];
    end
  end

  // configuration and path totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= DURATION_RST;
      min_r <= MIN_SEG_RST;
      cnt_r <= '0;
      tot_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DURATION: dur_r <= cfg_data;
          CFG_MIN_SEG:  min_r <= cfg_data[MIN_W-1:0];
          default:      dur_r <= dur_r;
        endcase
      end
      if (cmd.op == DP_FIRST) begin
        cnt_r <= CW'(1);
        tot_r <= '0;
      end else if (cmd.op == DP_APPEND) begin
        cnt_r <= cnt_r + CW'(1);
        tot_r <= len_sat;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LATCH: begin
        op_r     <= in_operation;
        pin_r[0] <= in_pos_x;
        pin_r[1] <= in_pos_y;
        pin_r[2] <= in_pos_z;
        el_r     <= in_elapsed_us;
        fin_r    <= (in_operation == OP_SAMPLE) && (in_elapsed_us >= dur_r);
        acc_r    <= 1'b0;
        w_r[0]   <= '0;
        w_r[1]   <= '0;
        w_r[2]   <= '0;
      end
      DP_FIRST, DP_APPEND: acc_r <= 1'b1;
      DP_SQ_X: begin
        d2_r <= dsq;
        m2_r <= min_r * min_r;
      end
      DP_SQ_Y, DP_SQ_Z: d2_r <= d2_r + dsq;
      DP_SQRT_INIT: begin
        sq_v_r <= d2_r;
        sq_r_r <= '0;
        sq_b_r <= D2_W'(1) << 48;
      end
      DP_SQRT_STEP: begin
        if (sq_v_r >= sq_t) begin
          sq_v_r <= sq_v_r - sq_t;
          sq_r_r <= (sq_r_r >> 1) + sq_b_r;
        end else begin
          sq_r_r <= sq_r_r >> 1;
        end
        sq_b_r <= sq_b_r >> 2;
      end
      DP_CMD_RD: begin
        w_r[0] <= rd_r[0];
        w_r[1] <= rd_r[1];
        w_r[2] <= rd_r[2];
      end
      DP_DIV_T: begin
        rem_r <= tdvd[DVD_W-1:QUO_W];
        dq_r  <= tdvd[QUO_W-1:0];
        dv_r  <= dur_r;
      end
      DP_DIV_STEP: begin
        rem_r <= tge ? 32'(trial - {1'b0, dv_r}) : trial[31:0];
        dq_r  <= {dq_r[QUO_W-2:0], tge};
      end
      DP_POW_INIT: begin
        t_r  <= {1'b0, dq_r[15:0]};
        pw_r <= {1'b0, dq_r[15:0]};
        p_r  <= '0;
      end
      DP_POW:   pw_r <= pw_rnd[32:16];
      DP_ACC10: p_r <= p_r + $signed({6'd0, pw_r}) * 23'sd10;
      DP_ACC15: p_r <= p_r - $signed({6'd0, pw_r}) * 23'sd15;
      DP_ACC6:  p_r <= p_r + $signed({6'd0, pw_r}) * 23'sd6;
      DP_TARGET: tgt_r <= tprod[47:16];
      DP_SRCH_INIT: begin
        lo_r <= AW'(1);
        hi_r <= cnt_m1[AW-1:0];
      end
      DP_SRCH_RD: mid_r <= mid;
      DP_SRCH_CMP: begin
        if (tgt_r <= rd_c_r) hi_r <= mid_r;
        else lo_r <= mid_r + AW'(1);
      end
      DP_CAP_K: begin
        pb_r[0] <= rd_r[0];
        pb_r[1] <= rd_r[1];
        pb_r[2] <= rd_r[2];
        c1_r    <= rd_c_r;
      end
      DP_CAP_J: begin
        pa_r[0] <= rd_r[0];
        pa_r[1] <= rd_r[1];
        pa_r[2] <= rd_r[2];
        c0_r    <= rd_c_r;
      end
      DP_SEG: begin
        seg_r      <= c1_r - c0_r;
        num_r      <= tgt_r - c0_r;
        seg_zero_r <= (c1_r == c0_r);
      end
      DP_CMD_J: begin
        w_r[0] <= pa_r[0];
        w_r[1] <= pa_r[1];
        w_r[2] <= pa_r[2];
      end
      DP_LERP_MUL: begin
        neg_r <= ldiff[24];
        rem_r <= ldvd[DVD_W-1:QUO_W];
        dq_r  <= ldvd[QUO_W-1:0];
        dv_r  <= seg_r;
      end
      DP_LERP_OUT: w_r[cmd.axis] <= lres[23:0];
      default: begin
        op_r <= op_r;
      end
    endcase
  end

  assign cnt_ext = {9'd0, cnt_r};

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cmd_x          <= w_r[0];
      out_cmd_y          <= w_r[1];
      out_cmd_z          <= w_r[2];
      out_path_ready     <= stat.ready;
      out_finished       <= fin_r;
      out_point_accepted <= acc_r;
      out_point_count    <= cnt_ext[8:0];
      out_path_length_um <= tot_r;
    end
  end

  always_comb begin
    stat.op        = op_r;
    stat.cnt_zero  = (cnt_r == '0);
    stat.full      = (cnt_r >= CW'(MAX_POINTS));
    stat.fin       = fin_r;
    stat.ready     = (cnt_r >= CW'(2)) && (tot_r != '0);
    stat.d2_gt     = d2_r > D2_W'(m2_r);
    stat.srch_more = lo_r < hi_r;
    stat.seg_zero  = seg_zero_r;
  end

endmodule

@@ rtl/qpps_ctrl.sv @@
// Controller: sequences the datapath through one word at a time.
`timescale 1ns / 1ps
module qpps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  qpps_pkg::dp_stat_t  stat,
  output qpps_pkg::dp_cmd_t   cmd
);
  import qpps_pkg::*;

  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_DISP  = 6'd1;
  localparam logic [5:0] S_FIRST = 6'd2;
  localparam logic [5:0] S_RDLA  = 6'd3;
  localparam logic [5:0] S_SQX   = 6'd4;
  localparam logic [5:0] S_SQY   = 6'd5;
  localparam logic [5:0] S_SQZ   = 6'd6;
  localparam logic [5:0] S_CMP   = 6'd7;
  localparam logic [5:0] S_SQI   = 6'd8;
  localparam logic [5:0] S_SQS   = 6'd9;
  localparam logic [5:0] S_APP   = 6'd10;
  localparam logic [5:0] S_RDLS  = 6'd11;
  localparam logic [5:0] S_RD0   = 6'd12;
  localparam logic [5:0] S_OUTRD = 6'd13;
  localparam logic [5:0] S_DIV0  = 6'd14;
  localparam logic [5:0] S_DIVT  = 6'd15;
  localparam logic [5:0] S_PINIT = 6'd16;
  localparam logic [5:0] S_P2    = 6'd17;
  localparam logic [5:0] S_P3    = 6'd18;
  localparam logic [5:0] S_A10   = 6'd19;
  localparam logic [5:0] S_P4    = 6'd20;
  localparam logic [5:0] S_A15   = 6'd21;
  localparam logic [5:0] S_P5    = 6'd22;
  localparam logic [5:0] S_A6    = 6'd23;
  localparam logic [5:0] S_TGT   = 6'd24;
  localparam logic [5:0] S_SRI   = 6'd25;
  localparam logic [5:0] S_SRCH  = 6'd26;
  localparam logic [5:0] S_SCMP  = 6'd27;
  localparam logic [5:0] S_CAPK  = 6'd28;
  localparam logic [5:0] S_CAPJ  = 6'd29;
  localparam logic [5:0] S_SEG   = 6'd30;
  localparam logic [5:0] S_SEGD  = 6'd31;
  localparam logic [5:0] S_CMDJ  = 6'd32;
  localparam logic [5:0] S_LMUL  = 6'd33;
  localparam logic [5:0] S_LDIV  = 6'd34;
  localparam logic [5:0] S_LOUT  = 6'd35;
  localparam logic [5:0] S_DONE  = 6'd36;

  logic [5:0]        state_r, state_nxt;
  logic [STEP_W-1:0] iter_r, iter_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    iter_nxt     = iter_r;
    axis_nxt     = axis_r;
    cmd.op       = DP_NOP;
    cmd.axis     = axis_r;
    cmd.load_out = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.op == OP_START || (stat.op == OP_APPEND && stat.cnt_zero)) begin
          state_nxt = S_FIRST;
        end else if (stat.op == OP_APPEND) begin
          state_nxt = stat.full ? S_DONE : S_RDLA;
        end else if (stat.op == OP_SAMPLE) begin
          if (!stat.ready) state_nxt = stat.cnt_zero ? S_DONE : S_RD0;
          else if (stat.fin) state_nxt = S_RDLS;
          else state_nxt = S_DIV0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIRST: begin
        cmd.op    = DP_FIRST;
        state_nxt = S_DONE;
      end
      S_RDLA: begin
        cmd.op    = DP_RD_LAST;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.op    = DP_SQ_X;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = DP_SQ_Y;
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        cmd.op    = DP_SQ_Z;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = stat.d2_gt ? S_SQI : S_DONE;
      end
      S_SQI: begin
        cmd.op    = DP_SQRT_INIT;
        iter_nxt  = '0;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op   = DP_SQRT_STEP;
        iter_nxt = iter_r + STEP_W'(1);
        if (iter_r == SQRT_LAST) state_nxt = S_APP;
      end
      S_APP: begin
        cmd.op    = DP_APPEND;
        state_nxt = S_DONE;
      end
      S_RDLS: begin
        cmd.op    = DP_RD_LAST;
        state_nxt = S_OUTRD;
      end
      S_RD0: begin
        cmd.op    = DP_RD_FIRST;
        state_nxt = S_OUTRD;
      end
      S_OUTRD: begin
        cmd.op    = DP_CMD_RD;
        state_nxt = S_DONE;
      end
      S_DIV0: begin
        cmd.op    = DP_DIV_T;
        iter_nxt  = '0;
        state_nxt = S_DIVT;
      end
      S_DIVT: begin
        cmd.op   = DP_DIV_STEP;
        iter_nxt = iter_r + STEP_W'(1);
        if (iter_r == DIV_LAST) state_nxt = S_PINIT;
      end
      S_PINIT: begin
        cmd.op    = DP_POW_INIT;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.op    = DP_POW;
        state_nxt = S_P3;
      end
      S_P3: begin
        cmd.op    = DP_POW;
        state_nxt = S_A10;
      end
      S_A10: begin
        cmd.op    = DP_ACC10;
        state_nxt = S_P4;
      end
      S_P4: begin
        cmd.op    = DP_POW;
        state_nxt = S_A15;
      end
      S_A15: begin
        cmd.op    = DP_ACC15;
        state_nxt = S_P5;
      end
      S_P5: begin
        cmd.op    = DP_POW;
        state_nxt = S_A6;
      end
      S_A6: begin
        cmd.op    = DP_ACC6;
        state_nxt = S_TGT;
      end
      S_TGT: begin
        cmd.op    = DP_TARGET;
        state_nxt = S_SRI;
      end
      S_SRI: begin
        cmd.op    = DP_SRCH_INIT;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (stat.srch_more) begin
          cmd.op    = DP_SRCH_RD;
          state_nxt = S_SCMP;
        end else begin
          cmd.op    = DP_RD_K;
          state_nxt = S_CAPK;
        end
      end
      S_SCMP: begin
        cmd.op    = DP_SRCH_CMP;
        state_nxt = S_SRCH;
      end
      S_CAPK: begin
        cmd.op    = DP_CAP_K;
        state_nxt = S_CAPJ;
      end
      S_CAPJ: begin
        cmd.op    = DP_CAP_J;
        state_nxt = S_SEG;
      end
      S_SEG: begin
        cmd.op    = DP_SEG;
        state_nxt = S_SEGD;
      end
      S_SEGD: begin
        axis_nxt  = AX_X;
        state_nxt = stat.seg_zero ? S_CMDJ : S_LMUL;
      end
      S_CMDJ: begin
        cmd.op    = DP_CMD_J;
        state_nxt = S_DONE;
      end
      S_LMUL: begin
        cmd.op    = DP_LERP_MUL;
        iter_nxt  = '0;
        state_nxt = S_LDIV;
      end
      S_LDIV: begin
        cmd.op   = DP_DIV_STEP;
        iter_nxt = iter_r + STEP_W'(1);
        if (iter_r == DIV_LAST) state_nxt = S_LOUT;
      end
      S_LOUT: begin
        cmd.op = DP_LERP_OUT;
        if (axis_r == AX_Z) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_LMUL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      axis_r      <= AX_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/qpps_chk.sv @@
// Port-level checker for the path sampler, bound to the top level.
`timescale 1ns / 1ps
module qpps_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] out_cmd_x,
  input logic               out_path_ready,
  input logic               out_finished,
  input logic               out_point_accepted,
  input logic [8:0]         out_point_count,
  input logic [31:0]        out_path_length_um
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd_x) && $stable(out_point_count))
    else $error("result word changed while stalled");

  // one word in flight: input closes right after a take
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

  // a stored point and a finished sample never share a word
  a_acc_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_point_accepted && out_finished))
    else $error("point_accepted and finished both set");

  // a ready path has length
  a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_ready |-> out_path_length_um != 32'd0)
    else $error("path_ready with zero length");

endmodule

bind quintic_polyline_path_sampler_unit qpps_chk u_qpps_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_cmd_x          (out_cmd_x),
  .out_path_ready     (out_path_ready),
  .out_finished       (out_finished),
  .out_point_accepted (out_point_accepted),
  .out_point_count    (out_point_count),
  .out_path_length_um (out_path_length_um)
);
